[src/afp_pkg.sv]
// Shared constants and types for the frame parser.
`timescale 1ns / 1ps

package afp_pkg;

   // Frame format constants.
   localparam logic [7:0] PREAMBLE    = 8'h3B;
   localparam int         MAX_PAYLOAD = 16;
   localparam logic [7:0] HDR_LEN     = 8'd3;
   localparam logic [7:0] MAX_LEN     = 8'(3 + MAX_PAYLOAD);

   // Field widths.
   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;
   localparam int IDX_W  = 4;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROP    = 2'd2;

   // One result item as produced by the parser core.
   typedef struct packed {
      logic                  valid;
      logic [KIND_W-1:0]     kind;
      logic [BYTE_W-1:0]     payload_byte;
      logic [IDX_W-1:0]      payload_index;
      logic [BYTE_W-1:0]     frame_len;
      logic [BYTE_W-1:0]     source_addr;
      logic [BYTE_W-1:0]     dest_addr;
      logic [BYTE_W-1:0]     command_code;
      logic [BYTE_W-1:0]     received_check;
      logic [BYTE_W-1:0]     computed_check;
      logic                  check_ok;
   } afp_result_type;

endpackage

[src/afp_if.sv]
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface afp_req_if;
   logic                       valid;
   logic                       ready;
   logic [afp_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface afp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [afp_pkg::KIND_W-1:0] kind;
   logic [afp_pkg::BYTE_W-1:0] payload_byte;
   logic [afp_pkg::IDX_W-1:0]  payload_index;
   logic [afp_pkg::BYTE_W-1:0] frame_len;
   logic [afp_pkg::BYTE_W-1:0] source_addr;
   logic [afp_pkg::BYTE_W-1:0] dest_addr;
   logic [afp_pkg::BYTE_W-1:0] command_code;
   logic [afp_pkg::BYTE_W-1:0] received_check;
   logic [afp_pkg::BYTE_W-1:0] computed_check;
   logic                       check_ok;

   modport source (output valid, output kind, output payload_byte, output payload_index,
                   output frame_len, output source_addr, output dest_addr,
                   output command_code, output received_check, output computed_check,
                   output check_ok, input ready);
   modport sink   (input valid, input kind, input payload_byte, input payload_index,
                   input frame_len, input source_addr, input dest_addr,
                   input command_code, input received_check, input computed_check,
                   input check_ok, output ready);
endinterface

[src/afp_parse_core.sv]
// Frame parser state registers and per-byte next-state and result logic.
`timescale 1ns / 1ps

module afp_parse_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       byte_take,
   input  logic [afp_pkg::BYTE_W-1:0] byte_data,
   output afp_pkg::afp_result_type    result
);

   // Header byte slots, indexed by the position after the length byte.
   localparam logic [1:0] POS_SRC = 2'd0;
   localparam logic [1:0] POS_DST = 2'd1;

   logic                       in_frame_ff, in_frame_in;
   logic [afp_pkg::BYTE_W-1:0] len_ff, len_in;
   logic [afp_pkg::BYTE_W-1:0] pos_ff, pos_in;
   logic [afp_pkg::BYTE_W-1:0] src_ff, src_in;
   logic [afp_pkg::BYTE_W-1:0] dst_ff, dst_in;
   logic [afp_pkg::BYTE_W-1:0] cmd_ff, cmd_in;
   logic [afp_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [afp_pkg::BYTE_W-1:0] sum_add;
   logic [afp_pkg::BYTE_W-1:0] check_calc;
   logic [afp_pkg::BYTE_W-1:0] idx_full;
   logic                       len_bad;

   assign sum_add    = sum_ff + byte_data;
   assign check_calc = 8'(8'd0 - sum_ff);
   assign idx_full   = pos_ff - afp_pkg::HDR_LEN;
   assign len_bad    = (byte_data < afp_pkg::HDR_LEN) || (byte_data > afp_pkg::MAX_LEN);

   // Next state and result for the byte being transferred in.
   always_comb begin
      in_frame_in = in_frame_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      cmd_in      = cmd_ff;
      sum_in      = sum_ff;
      result      = '0;

      if (byte_take) begin
         if (!in_frame_ff) begin
            // Hunting: only the preamble starts a frame.
            if (byte_data == afp_pkg::PREAMBLE) begin
               in_frame_in = 1'b1;
               pos_in      = '0;
               len_in      = '0;
               src_in      = '0;
               dst_in      = '0;
               cmd_in      = '0;
               sum_in      = '0;
            end
         end else if (len_ff == '0) begin
            // Length byte: either drop the frame or start the checksum.
            len_in = byte_data;
            pos_in = '0;
            if (len_bad) begin
               src_in         = '0;
               dst_in         = '0;
               cmd_in         = '0;
               in_frame_in    = 1'b0;
               result.valid   = 1'b1;
               result.kind    = afp_pkg::KIND_DROP;
            end else begin
               sum_in = byte_data;
            end
         end else if (pos_ff < afp_pkg::HDR_LEN) begin
            // Source, destination and command bytes.
            case (pos_ff[1:0])
               POS_SRC: src_in = byte_data;
               POS_DST: dst_in = byte_data;
               default: cmd_in = byte_data;
            endcase
            sum_in = sum_add;
            pos_in = pos_ff + 8'd1;
         end else if (pos_ff == len_ff) begin
            // Checksum byte closes the frame.
            in_frame_in           = 1'b0;
            pos_in                = '0;
            result.valid          = 1'b1;
            result.kind           = afp_pkg::KIND_DONE;
            result.received_check = byte_data;
            result.computed_check = check_calc;
            result.check_ok       = (byte_data == check_calc);
         end else begin
            // Payload byte.
            sum_in               = sum_add;
            pos_in               = pos_ff + 8'd1;
            result.valid         = 1'b1;
            result.kind          = afp_pkg::KIND_PAYLOAD;
            result.payload_byte  = byte_data;
            result.payload_index = idx_full[afp_pkg::IDX_W-1:0];
         end
      end

      // Header fields always reflect the frame after this byte.
      result.frame_len    = len_in;
      result.source_addr  = src_in;
      result.dest_addr    = dst_in;
      result.command_code = cmd_in;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         len_ff      <= '0;
         pos_ff      <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
         cmd_ff      <= '0;
         sum_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         len_ff      <= len_in;
         pos_ff      <= pos_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         cmd_ff      <= cmd_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

[src/afp_out_reg.sv]
// Result register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps

module afp_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  afp_pkg::afp_result_type result,
   output logic                    can_accept,
   afp_rsp_if.source               rsp_if
);

   logic                    valid_ff, valid_in;
   afp_pkg::afp_result_type data_ff;

   // A new item may enter when the register is empty or being emptied.
   assign can_accept = !valid_ff || rsp_if.ready;

   // Valid flag: set on load, cleared once the result is transferred out.
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.kind           = data_ff.kind;
   assign rsp_if.payload_byte   = data_ff.payload_byte;
   assign rsp_if.payload_index  = data_ff.payload_index;
   assign rsp_if.frame_len      = data_ff.frame_len;
   assign rsp_if.source_addr    = data_ff.source_addr;
   assign rsp_if.dest_addr      = data_ff.dest_addr;
   assign rsp_if.command_code   = data_ff.command_code;
   assign rsp_if.received_check = data_ff.received_check;
   assign rsp_if.computed_check = data_ff.computed_check;
   assign rsp_if.check_ok       = data_ff.check_ok;

endmodule

[src/aux_frame_parser_top.sv]
// A result appears at the output in the cycle after the byte that causes it is transferred in.
// Throughput: one byte per cycle while the output is not stalled; the parser state updates once per byte.
// The input stalls only while a result sits in the output register and is not taken.
// Reset (synchronous, active high) empties the output register and returns the
// parser to hunting for the preamble with all header and checksum state cleared.
`timescale 1ns / 1ps

module aux_frame_parser_top (
   input  logic      clock,
   input  logic      reset,
   afp_req_if.sink   req_if,
   afp_rsp_if.source rsp_if
);

   logic                    can_accept;
   logic                    byte_take;
   afp_pkg::afp_result_type result;

   // Input transfer happens whenever a byte is offered and the output side has room.
   assign req_if.ready = can_accept;
   assign byte_take    = req_if.valid && can_accept;

   afp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .byte_data (req_if.data_byte),
      .result    (result)
   );

   afp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (result.valid),
      .result     (result),
      .can_accept (can_accept),
      .rsp_if     (rsp_if)
   );

endmodule
